@@ src/rds_group_encoder_macros.svh @@
// Assertion macros for the RDS group encoder.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef RDS_GROUP_ENCODER_MACROS_SVH
`define RDS_GROUP_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property at each clock edge, skipped while reset is asserted
`define RDSGE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every clock edge, reset included
`define RDSGE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDSGE_ASSERT(label, clk, rst_n, prop, msg)
`define RDSGE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ src/rdsge_pkg.sv @@
// Shared types, constants and helper functions of the RDS group encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rdsge_pkg;

    // Group geometry
    localparam int GROUP_BYTES = 13;
    localparam int GROUP_BITS  = 104;
    localparam int BLOCKS      = 4;
    localparam int BLOCK_BITS  = 26;

    // Check word
    localparam logic [9:0] CRC_POLY = 10'h1B9;
    localparam logic [9:0] OFFSET_WORD [BLOCKS] = '{10'h0FC, 10'h198, 10'h168, 10'h1B4};

    // Programme service constants
    localparam logic [15:0] AF_FILLER     = 16'hCDCD;
    localparam logic [10:0] AF_BASE       = 11'd875;
    localparam logic [7:0]  AF_COUNT_BASE = 8'd224;

    // Clock time constants
    localparam logic [16:0] MJD_BASE     = 17'd14956;
    localparam logic [11:0] YEAR_DAYS_X4 = 12'd1461;
    localparam int          OFFSET_STEP  = 1800;
    localparam int          OFFSET_STEPS = 18;

    // Group type codes, block B bits 15:12
    localparam logic [3:0] GT_PS = 4'd0;
    localparam logic [3:0] GT_RT = 4'd2;
    localparam logic [3:0] GT_CT = 4'd4;

    // Item mode codes; the unused mode yields no group
    localparam logic [1:0] MODE_PS   = 2'd0;
    localparam logic [1:0] MODE_RT   = 2'd1;
    localparam logic [1:0] MODE_CT   = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_PI_CODE          = 3'd0;
    localparam logic [2:0] CFG_TRAFFIC_PROGRAM  = 3'd1;
    localparam logic [2:0] CFG_PROGRAM_TYPE     = 3'd2;
    localparam logic [2:0] CFG_TRAFFIC_ANNOUNCE = 3'd3;
    localparam logic [2:0] CFG_MUSIC_SPEECH     = 3'd4;
    localparam logic [2:0] CFG_MONO             = 3'd5;
    localparam logic [2:0] CFG_AF_COUNT         = 3'd6;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         segment;
        logic [31:0]        text_chars;
        logic [10:0]        af_first;
        logic [10:0]        af_second;
        logic [7:0]         year_since_1900;
        logic [3:0]         month;
        logic [4:0]         day;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic signed [15:0] utc_offset;
    } t_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [15:0] pi_code;
        logic        traffic_program;
        logic [4:0]  program_type;
        logic        traffic_announce;
        logic        music_speech;
        logic        mono;
        logic [4:0]  af_count;
    } t_cfg;

    typedef logic [GROUP_BITS-1:0] t_group;

    typedef struct packed {
        logic   valid;
        t_group group;
    } t_push;

    // Advance the 10-bit check word over one byte, MSB first
    function automatic logic [9:0] crc_byte(input logic [9:0] c_in, input logic [7:0] b);
        logic [9:0] c;
        logic       fb;
        c = c_in;
        for (int j = 7; j >= 0; j--) begin
            fb = b[j] ^ c[9];
            c  = {c[8:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // floor(m * 30.6001) for the shifted month index used by the day count
    function automatic logic [9:0] month_term(input logic [4:0] m);
        logic [9:0] t;
        unique case (m)
            5'd4:    t = 10'd122;
            5'd5:    t = 10'd153;
            5'd6:    t = 10'd183;
            5'd7:    t = 10'd214;
            5'd8:    t = 10'd244;
            5'd9:    t = 10'd275;
            5'd10:   t = 10'd306;
            5'd11:   t = 10'd336;
            5'd12:   t = 10'd367;
            5'd13:   t = 10'd397;
            5'd14:   t = 10'd428;
            5'd15:   t = 10'd459;
            5'd16:   t = 10'd489;
            5'd17:   t = 10'd520;
            default: t = 10'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

@@ src/rdsge_front.sv @@
// Front end of the RDS group encoder: takes items, drops unused modes,
// builds the four blocks and their check words. Depends on rdsge_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdsge_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire rdsge_pkg::t_item i_item,
    input  wire rdsge_pkg::t_cfg  i_cfg,
    output logic [1:0]            o_inflight,
    output rdsge_pkg::t_push      o_push
);
    import rdsge_pkg::*;

    // Stage 1 registers
    logic               r_s1_v;
    t_item              r_s1_item;
    logic signed [19:0] r_s1_yprod;
    logic [9:0]         r_s1_mterm;
    logic [4:0]         r_s1_offmag;
    logic               r_s1_offneg;

    // Stage 2 registers
    logic        r_s2_v;
    logic [15:0] r_s2_blk    [BLOCKS];
    logic [9:0]  r_s2_crc_hi [BLOCKS];

    // Accept-side arithmetic
    logic               w_mode_ok;
    logic               w_l;
    logic signed [8:0]  w_ysum;
    logic signed [19:0] w_yprod;
    logic [4:0]         w_midx;
    logic [15:0]        w_off_abs;
    logic [4:0]         w_offmag;

    // Classify the mode: only PS, RT and CT produce a group
    always_comb begin
        unique case (i_item.mode)
            MODE_PS, MODE_RT, MODE_CT: w_mode_ok = 1'b1;
            default:                   w_mode_ok = 1'b0;
        endcase
    end

    // Year and month terms of the day count
    assign w_l     = (i_item.month <= 4'd1);
    assign w_ysum  = $signed({1'b0, i_item.year_since_1900}) - $signed({8'b0, w_l});
    assign w_yprod = w_ysum * $signed({1'b0, YEAR_DAYS_X4});
    assign w_midx  = {1'b0, i_item.month} + 5'd2 + (w_l ? 5'd12 : 5'd0);

    // Offset magnitude in half hours, truncated toward zero
    assign w_off_abs = i_item.utc_offset[15] ? 16'(-i_item.utc_offset)
                                             : 16'(i_item.utc_offset);
    always_comb begin
        w_offmag = 5'd0;
        for (int k = 1; k <= OFFSET_STEPS; k++) begin
            if (w_off_abs >= 16'(k * OFFSET_STEP)) begin
                w_offmag = 5'(k);
            end
        end
    end

    // Stage 1: capture the item and its products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_accept && w_mode_ok;
        end
        r_s1_item   <= i_item;
        r_s1_yprod  <= w_yprod;
        r_s1_mterm  <= month_term(w_midx);
        r_s1_offmag <= w_offmag;
        r_s1_offneg <= i_item.utc_offset[15] && (w_offmag != 5'd0);
    end

    // Day count and block contents from stage 1
    logic signed [19:0] w_yadj;
    logic signed [19:0] w_yterm;
    logic [19:0]        w_mjd;
    logic [1:0]         w_gn;
    logic [7:0]         w_af1_byte;
    logic [7:0]         w_af2_byte;
    logic [15:0]        w_blk [BLOCKS];

    assign w_yadj  = r_s1_yprod[19] ? (r_s1_yprod + 20'sd3) : r_s1_yprod;
    assign w_yterm = w_yadj >>> 2;
    assign w_mjd   = $unsigned(w_yterm) + {3'b0, MJD_BASE} + {15'b0, r_s1_item.day}
                   + {10'b0, r_s1_mterm};

    assign w_gn       = r_s1_item.segment[1:0];
    assign w_af1_byte = (r_s1_item.af_first > AF_BASE) ? 8'(r_s1_item.af_first - AF_BASE)
                                                       : AF_FILLER[15:8];
    assign w_af2_byte = (r_s1_item.af_second > AF_BASE) ? 8'(r_s1_item.af_second - AF_BASE)
                                                        : AF_FILLER[7:0];

    // Build blocks A to D for the item's mode
    always_comb begin
        w_blk[0] = i_cfg.pi_code;
        unique case (r_s1_item.mode)
            MODE_PS: begin
                w_blk[1] = {GT_PS, 1'b0, i_cfg.traffic_program, i_cfg.program_type,
                            i_cfg.traffic_announce, i_cfg.music_speech,
                            i_cfg.mono && (w_gn == 2'd0), w_gn};
                if (w_gn == 2'd0) begin
                    w_blk[2] = {8'({3'b0, i_cfg.af_count} + AF_COUNT_BASE), AF_FILLER[7:0]};
                end else begin
                    w_blk[2] = {w_af1_byte, w_af2_byte};
                end
                w_blk[3] = r_s1_item.text_chars[31:16];
            end
            MODE_CT: begin
                w_blk[1] = {GT_CT, 1'b0, i_cfg.traffic_program, i_cfg.program_type,
                            3'b000, w_mjd[16:15]};
                w_blk[2] = {w_mjd[14:0], r_s1_item.hour[4]};
                w_blk[3] = {r_s1_item.hour[3:0], r_s1_item.minute, r_s1_offneg,
                            r_s1_offmag};
            end
            default: begin
                w_blk[1] = {GT_RT, 1'b0, i_cfg.traffic_program, i_cfg.program_type,
                            1'b0, r_s1_item.segment};
                w_blk[2] = r_s1_item.text_chars[31:16];
                w_blk[3] = r_s1_item.text_chars[15:0];
            end
        endcase
    end

    // Stage 2: hold blocks and the check word over their high bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        for (int i = 0; i < BLOCKS; i++) begin
            r_s2_blk[i]    <= w_blk[i];
            r_s2_crc_hi[i] <= crc_byte(10'd0, w_blk[i][15:8]);
        end
    end

    // Finish the check words, apply offsets and pack the group
    always_comb begin
        o_push.valid = r_s2_v;
        o_push.group = '0;
        for (int i = 0; i < BLOCKS; i++) begin
            o_push.group[GROUP_BITS-1-BLOCK_BITS*i -: BLOCK_BITS] =
                {r_s2_blk[i], crc_byte(r_s2_crc_hi[i], r_s2_blk[i][7:0]) ^ OFFSET_WORD[i]};
        end
    end

    assign o_inflight = {1'b0, r_s1_v} + {1'b0, r_s2_v};

endmodule

`default_nettype wire

@@ src/rdsge_fifo.sv @@
// Group queue between the front end and the byte serializer.
// Depends on rdsge_pkg for the group and push types.
`timescale 1ns / 1ps
`default_nettype none

module rdsge_fifo #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rdsge_pkg::t_push  i_push,
    input  wire logic              i_pop,
    output rdsge_pkg::t_group      o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import rdsge_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_group          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [CW-1:0]   n_count;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push.valid) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CW'(i_push.valid) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed group
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.group;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

@@ src/rdsge_back.sv @@
// Byte serializer of the RDS group encoder: shifts each queued group out
// as thirteen bytes, MSB first. Depends on rdsge_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rdsge_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_avail,
    input  wire rdsge_pkg::t_group i_head,
    output logic                   o_pop,
    output logic                   o_strobe,
    output rdsge_pkg::t_result     o_result
);
    import rdsge_pkg::*;

    localparam logic [3:0] LAST_POS = 4'(GROUP_BYTES - 1);

    logic       r_active;
    logic [3:0] r_pos;
    t_group     r_shift;
    logic       w_last;

    assign w_last = r_active && (r_pos == LAST_POS);

    // Take the next group when idle or on the final byte
    assign o_pop = i_avail && (!r_active || w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_pos    <= '0;
        end else if (w_last) begin
            r_active <= 1'b0;
            r_pos    <= '0;
        end else if (r_active) begin
            r_pos <= r_pos + 4'd1;
        end
    end

    // Load or shift the group word
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_shift <= i_head;
        end else begin
            r_shift <= {r_shift[GROUP_BITS-9:0], 8'h00};
        end
    end

    assign o_strobe           = r_active;
    assign o_result.data_byte = r_shift[GROUP_BITS-1 -: 8];
    assign o_result.last      = w_last;

endmodule

`default_nettype wire

@@ src/rds_group_encoder.sv @@
// Top level of the RDS group encoder: configuration registers, front end,
// group queue and byte serializer. Depends on rdsge_pkg and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rds_group_encoder_macros.svh"

// Each item accepted with start high and busy low builds one RDS group (PS
// type 0A, RT type 2A or CT type 4A) and yields thirteen bytes on o_result,
// one per cycle with o_strobe high, the last one flagged; mode 3 is taken and
// yields nothing. Results cannot be held off, so bytes of one group come in
// consecutive cycles. An item passes two front stages and the queue write,
// then the queue head loads the serializer, which drives the first byte; a
// group waits in the queue while an earlier one is still going out. The
// sustained rate is set by the one-byte result port. Items are taken back to
// back while bytes go out; busy rises only when the front stages and the
// queue together hold QUEUE_DEPTH groups. Config writes take effect at the
// next edge and are meant for idle periods. No clearing pass runs after reset.
module rds_group_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rdsge_pkg::t_item   i_item,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    output logic                    o_strobe,
    output rdsge_pkg::t_result      o_result
);
    import rdsge_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int OW = CW + 1;

    t_cfg          r_cfg;
    logic          w_accept;
    logic [1:0]    w_inflight;
    t_push         w_push;
    t_group        w_head;
    logic [CW-1:0] w_q_count;
    logic          w_pop;
    logic [OW-1:0] w_occ;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PI_CODE:          r_cfg.pi_code          <= i_cfg_data;
                CFG_TRAFFIC_PROGRAM:  r_cfg.traffic_program  <= i_cfg_data[0];
                CFG_PROGRAM_TYPE:     r_cfg.program_type     <= i_cfg_data[4:0];
                CFG_TRAFFIC_ANNOUNCE: r_cfg.traffic_announce <= i_cfg_data[0];
                CFG_MUSIC_SPEECH:     r_cfg.music_speech     <= i_cfg_data[0];
                CFG_MONO:             r_cfg.mono             <= i_cfg_data[0];
                CFG_AF_COUNT:         r_cfg.af_count         <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Hold off new items when pipeline and queue are full
    assign w_occ    = OW'(w_q_count) + OW'(w_inflight);
    assign busy     = (w_occ >= OW'(QUEUE_DEPTH));
    assign w_accept = start && !busy;

    rdsge_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .i_cfg      (r_cfg),
        .o_inflight (w_inflight),
        .o_push     (w_push)
    );

    rdsge_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_count (w_q_count)
    );

    rdsge_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (w_q_count != '0),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Checks
    `RDSGE_ASSERT(a_no_overflow, i_clk, i_rst_n, w_occ <= OW'(QUEUE_DEPTH), "queue overflow")
    `RDSGE_ASSERT(a_group_unbroken, i_clk, i_rst_n, o_strobe && !o_result.last |=> o_strobe, "group broken")
    `RDSGE_ASSERT(a_group_length, i_clk, i_rst_n, o_result.last |-> $past(o_strobe, GROUP_BYTES - 1), "short group")
    `RDSGE_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_strobe && !busy, "output after reset")

endmodule

`default_nettype wire

@@ sim/rds_group_check.sv @@
// Checker for the RDS group encoder: watches the item, register and byte channels,
// predicts each group's thirteen bytes and compares them in order.
// Depends on rdsge_pkg for the item, result and register types and constants.
`timescale 1ns / 1ps

module rds_group_check (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  rdsge_pkg::t_item       i_item,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [15:0]            i_cfg_data,
    input  logic                   i_strobe,
    input  rdsge_pkg::t_result     i_result,
    output int                     o_pending,
    output int                     o_errors
);
    import rdsge_pkg::*;

    t_cfg    regs;
    t_result byte_q[$];
    int      err_count;
    t_group  grp;
    t_result want;

    assign o_errors = err_count;

    initial begin
        err_count = 0;
        o_pending = 0;
    end

    // Print one line per failure (first few only) and count all of them
    task automatic report_mismatch(input string msg);
        if (err_count < 40) begin
            $display("%0t ns ERROR: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // 10-bit check word of one 16-bit block, MSB first
    function automatic logic [9:0] block_check(input logic [15:0] blk);
        logic [9:0] c;
        logic       fb;
        c = '0;
        for (int j = 15; j >= 0; j--) begin
            fb = blk[j] ^ c[9];
            c  = {c[8:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // Build the 104 group bits of one item: four blocks, each with its check word
    function automatic t_group encode_group(input t_item it, input t_cfg c);
        logic [15:0] blk [4];
        logic [10:0] diff;
        logic [7:0]  hi_byte, lo_byte;
        logic [1:0]  gn;
        logic [31:0] umjd;
        int          yr, mon, lf, mjd, q, mag;
        t_group      g;
        gn = it.segment[1:0];
        blk[0] = c.pi_code;
        blk[1] = '0;
        blk[2] = '0;
        blk[3] = '0;
        case (it.mode)
            MODE_PS: begin
                blk[1] = {GT_PS, 1'b0, c.traffic_program, c.program_type,
                          c.traffic_announce, c.music_speech,
                          (gn == 2'd0) && c.mono, gn};
                hi_byte = AF_FILLER[15:8];
                lo_byte = AF_FILLER[7:0];
                if (gn == 2'd0) begin
                    hi_byte = {3'b000, c.af_count} + AF_COUNT_BASE;
                end else begin
                    // AF codes above the base replace the filler byte
                    if (it.af_first > AF_BASE) begin
                        diff    = it.af_first - AF_BASE;
                        hi_byte = diff[7:0];
                    end
                    if (it.af_second > AF_BASE) begin
                        diff    = it.af_second - AF_BASE;
                        lo_byte = diff[7:0];
                    end
                end
                blk[2] = {hi_byte, lo_byte};
                blk[3] = it.text_chars[31:16];
            end
            MODE_RT: begin
                blk[1] = {GT_RT, 1'b0, c.traffic_program, c.program_type, 1'b0, it.segment};
                blk[2] = it.text_chars[31:16];
                blk[3] = it.text_chars[15:0];
            end
            MODE_CT: begin
                // Modified Julian Day in exact integer form
                yr  = int'(it.year_since_1900);
                mon = int'(it.month);
                lf  = (mon <= 1) ? 1 : 0;
                mjd = 14956 + int'(it.day) + ((yr - lf) * 1461) / 4
                      + ((mon + 2 + lf * 12) * 306001) / 10000;
                umjd = mjd;
                q    = int'(it.utc_offset) / 1800;
                mag  = (q < 0) ? -q : q;
                blk[1] = {GT_CT, 1'b0, c.traffic_program, c.program_type, 3'b000, umjd[16:15]};
                blk[2] = {umjd[14:0], it.hour[4]};
                blk[3] = {it.hour[3:0], it.minute, q < 0, mag[4:0]};
            end
            default: ;
        endcase
        g = '0;
        for (int i = 0; i < BLOCKS; i++) begin
            g = {g[GROUP_BITS-BLOCK_BITS-1:0], blk[i], block_check(blk[i]) ^ OFFSET_WORD[i]};
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '0;
            byte_q.delete();
            o_pending <= 0;
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PI_CODE:          regs.pi_code          = i_cfg_data;
                    CFG_TRAFFIC_PROGRAM:  regs.traffic_program  = i_cfg_data[0];
                    CFG_PROGRAM_TYPE:     regs.program_type     = i_cfg_data[4:0];
                    CFG_TRAFFIC_ANNOUNCE: regs.traffic_announce = i_cfg_data[0];
                    CFG_MUSIC_SPEECH:     regs.music_speech     = i_cfg_data[0];
                    CFG_MONO:             regs.mono             = i_cfg_data[0];
                    CFG_AF_COUNT:         regs.af_count         = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            // Queue the thirteen bytes of each accepted group; the unused mode yields none
            if (i_start && !i_busy && i_item.mode != MODE_NONE) begin
                grp = encode_group(i_item, regs);
                for (int n = 0; n < GROUP_BYTES; n++) begin
                    want.data_byte = grp[GROUP_BITS-1-8*n -: 8];
                    want.last      = (n == GROUP_BYTES - 1);
                    byte_q.push_back(want);
                end
            end
            // Compare each emitted byte with the oldest prediction
            if (i_strobe) begin
                if (byte_q.size() == 0) begin
                    report_mismatch($sformatf("byte %02h emitted with nothing pending",
                                              i_result.data_byte));
                end else begin
                    want = byte_q.pop_front();
                    if (i_result.data_byte !== want.data_byte) begin
                        report_mismatch($sformatf("data_byte got %02h want %02h",
                                                  i_result.data_byte, want.data_byte));
                    end
                    if (i_result.last !== want.last) begin
                        report_mismatch($sformatf("last got %b want %b",
                                                  i_result.last, want.last));
                    end
                end
            end
            o_pending <= byte_q.size();
        end
    end

endmodule

@@ sim/tb_rds_group_encoder.sv @@
// Top of the RDS group encoder testbench: clock, reset, item and register stimulus.
// Depends on rdsge_pkg, rds_group_encoder and the rds_group_check checker.
`timescale 1ns / 1ps

module tb_rds_group_encoder;
    import rdsge_pkg::*;

    localparam logic [2:0] CFG_UNUSED    = 3'd7;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASE_ITEMS   = 94;
    localparam int         PHASES        = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       cmd_item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        strobe;
    t_result     result;
    int          pending;
    int          check_errors;
    int          gap_pct;

    rds_group_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (cmd_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_strobe    (strobe),
        .o_result    (result)
    );

    rds_group_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (cmd_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_strobe    (strobe),
        .i_result    (result),
        .o_pending   (pending),
        .o_errors    (check_errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // AF code: around the base, in range, or any 11-bit value
    function automatic logic [10:0] pick_af();
        case ($urandom_range(0, 2))
            0:       return 11'($urandom_range(870, 880));
            1:       return 11'($urandom_range(0, 1130));
            default: return 11'($urandom);
        endcase
    endfunction

    // Random item of a given mode; fields mostly in range, sometimes anything
    function automatic t_item rand_item(input logic [1:0] mode);
        t_item it;
        int    k;
        it.mode            = mode;
        it.segment         = 4'($urandom);
        it.text_chars      = $urandom;
        it.af_first        = pick_af();
        it.af_second       = pick_af();
        it.year_since_1900 = 8'($urandom);
        it.month           = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 11));
        it.day             = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
        it.hour            = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
        it.minute          = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
        if ($urandom_range(0, 1) == 0) begin
            it.utc_offset = 16'($urandom);
        end else begin
            // Near a multiple of the half-hour step, to hit rounding edges
            k = int'($urandom_range(0, 36)) - 18;
            it.utc_offset = 16'(k * 1800 + int'($urandom_range(0, 2)) - 1);
        end
        return it;
    endfunction

    function automatic t_item ps_item(input logic [3:0] seg, input logic [10:0] af1,
                                      input logic [10:0] af2);
        t_item it;
        it           = rand_item(MODE_PS);
        it.segment   = seg;
        it.af_first  = af1;
        it.af_second = af2;
        return it;
    endfunction

    function automatic t_item ct_item(input logic [7:0] yr, input logic [3:0] mon,
                                      input logic [4:0] dy, input logic [4:0] hr,
                                      input logic [5:0] mi, input logic [15:0] off);
        t_item it;
        it                 = rand_item(MODE_CT);
        it.year_since_1900 = yr;
        it.month           = mon;
        it.day             = dy;
        it.hour            = hr;
        it.minute          = mi;
        it.utc_offset      = off;
        return it;
    endfunction

    // Offer one item, after an optional idle burst, and hold it until taken
    task automatic send_item(input t_item it);
        if (int'($urandom_range(0, 99)) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        start    <= 1'b1;
        cmd_item <= it;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(CFG_PI_CODE,          c.pi_code);
        write_reg(CFG_TRAFFIC_PROGRAM,  16'(c.traffic_program));
        write_reg(CFG_PROGRAM_TYPE,     16'(c.program_type));
        write_reg(CFG_TRAFFIC_ANNOUNCE, 16'(c.traffic_announce));
        write_reg(CFG_MUSIC_SPEECH,     16'(c.music_speech));
        write_reg(CFG_MONO,             16'(c.mono));
        write_reg(CFG_AF_COUNT,         16'(c.af_count));
        cfg_we <= 1'b0;
    endtask

    // Stop offering items and let every pending byte drain
    task automatic finish_phase();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // End the run when nothing moves for too long
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || strobe || cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_cfg       c;
        int         pick;
        logic [1:0] mode;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        cmd_item  <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        gap_pct   = 30;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items with registers at their reset values
        send_item(ps_item(4'd0, 11'd0, 11'd0));
        send_item(ps_item(4'd1, 11'd875, 11'd876));
        send_item(ps_item(4'd2, 11'd876, 11'd875));
        send_item(ps_item(4'd3, 11'd2047, 11'd0));
        send_item(ps_item(4'd7, 11'd1130, 11'd1130));
        send_item(rand_item(MODE_RT));
        send_item(rand_item(MODE_NONE));
        send_item(ct_item(8'd0, 4'd0, 5'd1, 5'd0, 6'd0, 16'd0));
        send_item(ct_item(8'd255, 4'd11, 5'd31, 5'd23, 6'd59, 16'h7FFF));
        send_item(ct_item(8'd0, 4'd1, 5'd31, 5'd16, 6'd1, 16'h8000));
        send_item(ct_item(8'd100, 4'd2, 5'd0, 5'd31, 6'd63, -16'sd1800));
        send_item(ct_item(8'd124, 4'd15, 5'd15, 5'd12, 6'd30, 16'd1799));
        send_item(ct_item(8'd1, 4'd12, 5'd28, 5'd1, 6'd2, -16'sd1799));
        finish_phase();

        // Directed items with every register at its top value
        c = '1;
        program_regs(c);
        send_item(ps_item(4'd0, 11'd0, 11'd2047));
        send_item(ps_item(4'd4, 11'd877, 11'd1130));
        send_item(ps_item(4'd13, 11'd1131, 11'd2047));
        send_item(rand_item(MODE_RT));
        send_item(rand_item(MODE_CT));
        send_item(rand_item(MODE_NONE));
        finish_phase();

        // Random phases, each under fresh register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            c = t_cfg'($urandom);
            c.pi_code = 16'($urandom);
            if (ph == 0) begin
                c.af_count = 5'd25;
            end
            if ($urandom_range(0, 1) == 0) begin
                write_reg(CFG_UNUSED, 16'($urandom));
            end
            program_regs(c);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 40;
            endcase
            if (ph == PHASES - 1) begin
                gap_pct = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    mode = MODE_NONE;
                end else if (pick <= 7) begin
                    mode = MODE_PS;
                end else if (pick <= 13) begin
                    mode = MODE_RT;
                end else begin
                    mode = MODE_CT;
                end
                send_item(rand_item(mode));
            end
            finish_phase();
        end

        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (check_errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
